// ----- hdl/dcbb_pkg.sv -----
// dcbb_pkg: shared types and constants for the buzzer burst generator.
// Used by the command interface, the burst core, the top level and the checker.
package dcbb_pkg;

  localparam int MaxPeriodTicks = 60000;
  localparam int MaxCycles      = 600;

  localparam int CmdW    = 3;
  localparam int DutyInW = 8;
  localparam int DutyW   = 7;
  localparam int PeriodW = 16;
  localparam int CountW  = 16;
  // duty (0..100) times period
  localparam int ProdW   = DutyW + PeriodW;
  // (tick position + 1) times 100
  localparam int ScaledW = PeriodW + 1 + DutyW;

  localparam logic [DutyW-1:0] DutyFull = 7'd100;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK      = 3'd0,
    CMD_PLAY      = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_FORCE_ON  = 3'd3,
    CMD_FORCE_OFF = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [DutyInW-1:0] duty_pct;
    logic [PeriodW-1:0] period_ticks;
    logic [CountW-1:0]  cycles_wanted;
  } cmd_t;

  typedef struct packed {
    logic pin_on;
    logic busy_res;
    logic finished;
  } res_t;

endpackage

// ----- hdl/dcbb_cmd_if.sv -----
// dcbb_cmd_if: command channel (valid/ready plus command payload).
// Depends on dcbb_pkg for field widths.
interface dcbb_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [dcbb_pkg::CmdW-1:0]        cmd;
  logic [dcbb_pkg::DutyInW-1:0]     duty_pct;
  logic [dcbb_pkg::PeriodW-1:0]     period_ticks;
  logic [dcbb_pkg::CountW-1:0]      cycles_wanted;

  modport source (output valid, output cmd, output duty_pct, output period_ticks,
                  output cycles_wanted, input ready);
  modport sink   (input valid, input cmd, input duty_pct, input period_ticks,
                  input cycles_wanted, output ready);
endinterface

// ----- hdl/dcbb_res_if.sv -----
// dcbb_res_if: result channel (valid/ready plus pin, busy and finished flags).
// Standalone; no package dependency.
interface dcbb_res_if;
  logic valid;
  logic ready;
  logic pin_on;
  logic busy_res;
  logic finished;

  modport source (output valid, output pin_on, output busy_res, output finished,
                  input ready);
  modport sink   (input valid, input pin_on, input busy_res, input finished,
                  output ready);
endinterface

// ----- hdl/dcbb_core.sv -----
// dcbb_core: burst state registers and the per-command next-state logic.
// Depends on dcbb_pkg. The result for a command is produced in its accept cycle.
module dcbb_core #(
  parameter int MAX_PERIOD_TICKS = dcbb_pkg::MaxPeriodTicks,
  parameter int MAX_CYCLES       = dcbb_pkg::MaxCycles
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  dcbb_pkg::cmd_t cmd_i,
  output dcbb_pkg::res_t res_o
);

  localparam int CycW = $clog2(MAX_CYCLES + 1);
  localparam logic [dcbb_pkg::PeriodW-1:0] PeriodMax = dcbb_pkg::PeriodW'(MAX_PERIOD_TICKS);
  localparam logic [dcbb_pkg::CountW-1:0]  CyclesMaxIn = dcbb_pkg::CountW'(MAX_CYCLES);
  localparam logic [CycW-1:0]              CyclesMax = CycW'(MAX_CYCLES);
  localparam logic [dcbb_pkg::DutyInW-1:0] DutyFullIn = {1'b0, dcbb_pkg::DutyFull};

  logic                             playing_q, playing_d;
  logic                             pin_q, pin_d;
  logic [dcbb_pkg::ProdW-1:0]       prod_q, prod_d;
  logic [dcbb_pkg::PeriodW-1:0]     period_q, period_d;
  logic [dcbb_pkg::PeriodW-1:0]     tick_q, tick_d;
  logic [CycW-1:0]                  target_q, target_d;
  logic [CycW-1:0]                  done_q, done_d;
  logic                             fin;

  logic [dcbb_pkg::PeriodW:0]       tick_plus;
  logic [dcbb_pkg::PeriodW-1:0]     tick_inc;
  logic [dcbb_pkg::ScaledW-1:0]     tick_scaled;
  logic [CycW-1:0]                  done_inc;
  logic [dcbb_pkg::PeriodW-1:0]     play_period;
  logic [CycW-1:0]                  play_cycles;
  logic [dcbb_pkg::DutyW-1:0]       play_duty;

  // pin is high while tick_pos < duty*period/100, i.e. (tick_pos+1)*100 <= duty*period
  assign tick_plus   = {1'b0, tick_q} + 1'b1;
  assign tick_inc    = tick_plus[dcbb_pkg::PeriodW-1:0];
  assign tick_scaled = (dcbb_pkg::ScaledW'(tick_plus) << 6) +
                       (dcbb_pkg::ScaledW'(tick_plus) << 5) +
                       (dcbb_pkg::ScaledW'(tick_plus) << 2);
  assign done_inc    = done_q + 1'b1;

  assign play_period = (cmd_i.period_ticks > PeriodMax) ? PeriodMax : cmd_i.period_ticks;
  assign play_cycles = (cmd_i.cycles_wanted > CyclesMaxIn) ? CyclesMax
                                                           : cmd_i.cycles_wanted[CycW-1:0];
  assign play_duty   = (cmd_i.duty_pct > DutyFullIn) ? dcbb_pkg::DutyFull
                                                     : cmd_i.duty_pct[dcbb_pkg::DutyW-1:0];

  always_comb begin
    playing_d = playing_q;
    pin_d     = pin_q;
    prod_d    = prod_q;
    period_d  = period_q;
    tick_d    = tick_q;
    target_d  = target_q;
    done_d    = done_q;
    fin       = 1'b0;
    unique case (dcbb_pkg::cmd_e'(cmd_i.cmd)) inside
      dcbb_pkg::CMD_TICK: begin
        if (playing_q) begin
          pin_d = (tick_scaled <= dcbb_pkg::ScaledW'(prod_q));
          if (tick_inc >= period_q) begin
            tick_d = '0;
            if (done_inc >= target_q) begin
              playing_d = 1'b0;
              pin_d     = 1'b0;
              prod_d    = '0;
              period_d  = '0;
              target_d  = '0;
              done_d    = '0;
              fin       = 1'b1;
            end else begin
              done_d = done_inc;
            end
          end else begin
            tick_d = tick_inc;
          end
        end
      end
      dcbb_pkg::CMD_PLAY: begin
        pin_d     = 1'b0;
        tick_d    = '0;
        done_d    = '0;
        period_d  = play_period;
        prod_d    = dcbb_pkg::ProdW'(play_duty) * dcbb_pkg::ProdW'(play_period);
        target_d  = (play_period != '0) ? play_cycles : '0;
        playing_d = (play_period != '0) && (play_cycles != '0);
      end
      dcbb_pkg::CMD_STOP, dcbb_pkg::CMD_FORCE_OFF, dcbb_pkg::CMD_FORCE_ON: begin
        playing_d = 1'b0;
        pin_d     = (dcbb_pkg::cmd_e'(cmd_i.cmd) == dcbb_pkg::CMD_FORCE_ON);
        prod_d    = '0;
        period_d  = '0;
        tick_d    = '0;
        target_d  = '0;
        done_d    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      pin_q     <= 1'b0;
      prod_q    <= '0;
      period_q  <= '0;
      tick_q    <= '0;
      target_q  <= '0;
      done_q    <= '0;
    end else if (accept_i) begin
      playing_q <= playing_d;
      pin_q     <= pin_d;
      prod_q    <= prod_d;
      period_q  <= period_d;
      tick_q    <= tick_d;
      target_q  <= target_d;
      done_q    <= done_d;
    end
  end

  assign res_o.pin_on   = pin_d;
  assign res_o.busy_res = playing_d;
  assign res_o.finished = fin;

endmodule

// ----- hdl/duty_cycled_beep_burst.sv -----
// duty_cycled_beep_burst: top level of the buzzer burst generator.
// Depends on dcbb_pkg, dcbb_cmd_if, dcbb_res_if and dcbb_core.
//
// Usage:
//   cmd_i carries one command per transaction: tick, play, stop, force-on or
//   force-off, with the play arguments (duty, period in ticks, period count).
//   res_o returns exactly one result per command: the pin level, whether a
//   burst is playing, and a finished flag on the tick that ends the last period.
// Latency: the result is valid the cycle after the command is accepted.
// Throughput: one command per cycle unless stalled; the burst state is updated
//   in the accept cycle by two counter increments, two compares and a
//   constant-scaled compare, with the duty*period product formed once at play time.
// Stalls: a single output register holds the pending result; cmd_i.ready is
//   high whenever that register is empty or being drained in the same cycle,
//   so a stalled receiver stops intake after one result.
// Reset: asynchronous, active low; the block comes up idle with the pin low
//   and no result pending.
module duty_cycled_beep_burst #(
  parameter int MAX_PERIOD_TICKS = dcbb_pkg::MaxPeriodTicks,
  parameter int MAX_CYCLES       = dcbb_pkg::MaxCycles
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcbb_cmd_if.sink   cmd_i,
  dcbb_res_if.source res_o
);

  logic           accept;
  dcbb_pkg::cmd_t cmd;
  dcbb_pkg::res_t res_d, res_q;
  logic           out_valid_q;

  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign cmd.cmd           = cmd_i.cmd;
  assign cmd.duty_pct      = cmd_i.duty_pct;
  assign cmd.period_ticks  = cmd_i.period_ticks;
  assign cmd.cycles_wanted = cmd_i.cycles_wanted;

  dcbb_core #(
    .MAX_PERIOD_TICKS(MAX_PERIOD_TICKS),
    .MAX_CYCLES      (MAX_CYCLES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .cmd_i   (cmd),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.pin_on   = res_q.pin_on;
  assign res_o.busy_res = res_q.busy_res;
  assign res_o.finished = res_q.finished;

endmodule

// ----- hdl/dcbb_checker.sv -----
// dcbb_checker: port-level assertions for duty_cycled_beep_burst, bound to the top.
// Depends on dcbb_pkg for command codes.
module dcbb_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cmd_valid_i,
  input logic                      cmd_ready_i,
  input logic [dcbb_pkg::CmdW-1:0] cmd_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic                      pin_on_i,
  input logic                      busy_res_i,
  input logic                      finished_i
);

  logic cmd_acc;
  assign cmd_acc = cmd_valid_i && cmd_ready_i;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(pin_on_i) && $stable(busy_res_i) && $stable(finished_i))
  else $error("stalled result changed");

  // the final period leaves the block idle with the pin low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && finished_i |-> !busy_res_i && !pin_on_i)
  else $error("finished burst still busy or pin high");

  // force-on ends any burst and drives the pin high, reported next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && (cmd_i == dcbb_pkg::CMD_FORCE_ON) |=>
      res_valid_i && pin_on_i && !busy_res_i && !finished_i)
  else $error("force-on result wrong");

  // only a tick can complete a burst; play always starts with the pin low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && (cmd_i != dcbb_pkg::CMD_TICK) |=>
      res_valid_i && !finished_i &&
      (!$past(cmd_i == dcbb_pkg::CMD_PLAY) || !pin_on_i))
  else $error("non-tick result wrong");

endmodule

bind duty_cycled_beep_burst dcbb_checker u_dcbb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cmd_valid_i(cmd_i.valid),
  .cmd_ready_i(cmd_i.ready),
  .cmd_i      (cmd_i.cmd),
  .res_valid_i(res_o.valid),
  .res_ready_i(res_o.ready),
  .pin_on_i   (res_o.pin_on),
  .busy_res_i (res_o.busy_res),
  .finished_i (res_o.finished)
);

// ----- tb/tb_duty_cycled_beep_burst.sv -----
// tb_duty_cycled_beep_burst: self-checking testbench for the buzzer burst generator.
// Needs dcbb_pkg, dcbb_cmd_if, dcbb_res_if and the duty_cycled_beep_burst RTL.
// Drives directed and random commands, predicts each result and checks it in order.
module tb_duty_cycled_beep_burst;

  // command codes the block ignores
  localparam logic [dcbb_pkg::CmdW-1:0] CmdRsvdLo = 3'd5;
  localparam logic [dcbb_pkg::CmdW-1:0] CmdRsvdHi = 3'd7;

  localparam int NumItems   = 1350;
  localparam int CalmItems  = 200;   // tail of the run without idling
  localparam int HoldCycles = 250;
  localparam int HoldAt     = 400;
  localparam int DrainAt    = 800;

  typedef struct {
    dcbb_pkg::cmd_t c;
    bit             chk;
    dcbb_pkg::res_t r;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  dcbb_cmd_if cmd_if ();
  dcbb_res_if res_if ();

  duty_cycled_beep_burst u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  // burst state as the block should hold it
  bit                           playing_q;
  logic [dcbb_pkg::DutyW-1:0]   duty_q;
  logic [dcbb_pkg::PeriodW-1:0] period_q;
  logic [dcbb_pkg::PeriodW-1:0] pos_q;
  logic [9:0]                   target_q;
  logic [9:0]                   done_q;
  bit                           pin_q;

  dcbb_pkg::res_t pin_status_q[$];
  dir_row_t       dir_rows[$];
  int             err_cnt;
  int             sent_cnt;
  bit             idle_en;
  bit             hold_req;
  int             stall_cnt;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic clear_burst();
    playing_q = 1'b0;
    duty_q    = '0;
    period_q  = '0;
    pos_q     = '0;
    target_q  = '0;
    done_q    = '0;
  endtask

  task automatic step_burst(input dcbb_pkg::cmd_t c, output dcbb_pkg::res_t r);
    int unsigned d32, p32, high_ticks, per, cyc;
    bit fin;
    fin = 1'b0;
    case (c.cmd) inside
      dcbb_pkg::CMD_TICK: begin
        if (playing_q) begin
          d32 = 32'(duty_q);
          p32 = 32'(period_q);
          high_ticks = d32 * p32 / 100;
          pin_q = (high_ticks > 0) && (pos_q < high_ticks);
          pos_q = pos_q + 16'd1;
          if (pos_q >= period_q) begin
            pos_q  = '0;
            done_q = done_q + 10'd1;
            if (done_q >= target_q) begin
              clear_burst();
              pin_q = 1'b0;
              fin   = 1'b1;
            end
          end
        end
      end
      dcbb_pkg::CMD_PLAY: begin
        per = (c.period_ticks > dcbb_pkg::MaxPeriodTicks) ? dcbb_pkg::MaxPeriodTicks
                                                          : 32'(c.period_ticks);
        cyc = (c.cycles_wanted > dcbb_pkg::MaxCycles) ? dcbb_pkg::MaxCycles
                                                      : 32'(c.cycles_wanted);
        clear_burst();
        pin_q  = 1'b0;
        duty_q = (c.duty_pct > dcbb_pkg::DutyFull) ? dcbb_pkg::DutyFull
                                                   : c.duty_pct[dcbb_pkg::DutyW-1:0];
        if (per != 0) begin
          period_q = per[dcbb_pkg::PeriodW-1:0];
          target_q = cyc[9:0];
          if (target_q != 0) playing_q = 1'b1;
        end
      end
      dcbb_pkg::CMD_STOP, dcbb_pkg::CMD_FORCE_OFF: begin
        clear_burst();
        pin_q = 1'b0;
      end
      dcbb_pkg::CMD_FORCE_ON: begin
        clear_burst();
        pin_q = 1'b1;
      end
      default: ;
    endcase
    r.pin_on   = pin_q;
    r.busy_res = playing_q;
    r.finished = fin;
  endtask

  function automatic dcbb_pkg::cmd_t mk_cmd(input logic [dcbb_pkg::CmdW-1:0] code,
                                            input int d, input int p, input int n);
    dcbb_pkg::cmd_t c;
    c.cmd           = code;
    c.duty_pct      = d[dcbb_pkg::DutyInW-1:0];
    c.period_ticks  = p[dcbb_pkg::PeriodW-1:0];
    c.cycles_wanted = n[dcbb_pkg::CountW-1:0];
    return c;
  endfunction

  function automatic dcbb_pkg::cmd_t rand_cmd();
    return mk_cmd(dcbb_pkg::CmdW'($urandom_range(0, 7)), $urandom_range(0, 255),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
  endfunction

  // chk set: the typed result is expected instead of the predicted one
  task automatic add_row(input logic [dcbb_pkg::CmdW-1:0] code, input int d, input int p,
                         input int n, input bit chk, input bit pin, input bit busy,
                         input bit fin);
    dir_row_t row;
    row.c          = mk_cmd(code, d, p, n);
    row.chk        = chk;
    row.r.pin_on   = pin;
    row.r.busy_res = busy;
    row.r.finished = fin;
    dir_rows.push_back(row);
  endtask

  // called at a clock edge; returns at the edge of the transaction or, with idling on, after a random idle gap
  task automatic send_cmd(input dcbb_pkg::cmd_t c, input bit use_typed,
                          input dcbb_pkg::res_t typed);
    dcbb_pkg::res_t r;
    cmd_if.valid         <= 1'b1;
    cmd_if.cmd           <= c.cmd;
    cmd_if.duty_pct      <= c.duty_pct;
    cmd_if.period_ticks  <= c.period_ticks;
    cmd_if.cycles_wanted <= c.cycles_wanted;
    do @(posedge clk_i); while (!(cmd_if.valid && cmd_if.ready));
    step_burst(c, r);
    pin_status_q.push_back(use_typed ? typed : r);
    sent_cnt++;
    if (idle_en && ($urandom_range(0, 4) == 0)) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic send_rand(input dcbb_pkg::cmd_t c);
    send_cmd(c, 1'b0, '0);
  endtask

  task automatic play_burst();
    int d, p, n, nt;
    d  = ($urandom_range(0, 4) == 0) ? $urandom_range(101, 255) : $urandom_range(0, 100);
    p  = $urandom_range(1, 8);
    n  = $urandom_range(1, 4);
    nt = p * n + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
    send_rand(mk_cmd(dcbb_pkg::CMD_PLAY, d, p, n));
    for (int i = 0; i < nt; i++) begin
      if ($urandom_range(0, 39) == 0) send_rand(rand_cmd());
      else send_rand(mk_cmd(dcbb_pkg::CMD_TICK, 0, 0, 0));
    end
  endtask

  // long or saturating burst, cut short by a stop or a force
  task automatic play_cut(input bit edge_vals);
    int p, n, k;
    dcbb_pkg::cmd_t c;
    if (edge_vals) begin
      case ($urandom_range(0, 2))
        0: p = 60000;
        1: p = 60001;
        default: p = 65535;
      endcase
      case ($urandom_range(0, 4))
        0: n = 600;
        1: n = 601;
        2: n = 1023;
        3: n = 1024;
        default: n = 65535;
      endcase
      c = mk_cmd(dcbb_pkg::CMD_PLAY, $urandom_range(0, 255), p, n);
    end else begin
      c = rand_cmd();
      c.cmd = dcbb_pkg::CMD_PLAY;
    end
    send_rand(c);
    k = $urandom_range(1, 12);
    repeat (k) send_rand(mk_cmd(dcbb_pkg::CMD_TICK, 0, 0, 0));
    case ($urandom_range(0, 2))
      0: send_rand(mk_cmd(dcbb_pkg::CMD_STOP, 0, 0, 0));
      1: send_rand(mk_cmd(dcbb_pkg::CMD_FORCE_ON, 0, 0, 0));
      default: send_rand(mk_cmd(dcbb_pkg::CMD_FORCE_OFF, 0, 0, 0));
    endcase
  endtask

  // result side: random stalls, long hold-offs, in-order checking
  initial begin
    dcbb_pkg::res_t want;
    bit             rdy;
    res_if.ready <= 1'b0;
    stall_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (pin_status_q.size() == 0) begin
          note_mismatch("result with nothing expected");
        end else begin
          want = pin_status_q.pop_front();
          if (res_if.pin_on !== want.pin_on)
            note_mismatch($sformatf("pin_on got %b want %b", res_if.pin_on, want.pin_on));
          if (res_if.busy_res !== want.busy_res)
            note_mismatch($sformatf("busy_res got %b want %b", res_if.busy_res,
                                    want.busy_res));
          if (res_if.finished !== want.finished)
            note_mismatch($sformatf("finished got %b want %b", res_if.finished,
                                    want.finished));
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_cnt = HoldCycles;
      end else if (stall_cnt == 0 && idle_en && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(1, 7);
      end
      rdy = (stall_cnt == 0);
      if (stall_cnt > 0) stall_cnt--;
      res_if.ready <= rdy;
    end
  end

  initial begin
    bit drained;
    int pick;
    cmd_if.valid         <= 1'b0;
    cmd_if.cmd           <= dcbb_pkg::CMD_TICK;
    cmd_if.duty_pct      <= '0;
    cmd_if.period_ticks  <= '0;
    cmd_if.cycles_wanted <= '0;
    rst_ni   = 1'b0;
    err_cnt  = 0;
    sent_cnt = 0;
    idle_en  = 1'b1;
    hold_req = 1'b0;
    drained  = 1'b0;
    clear_burst();
    pin_q = 1'b0;

    //       cmd                      duty period  cycles chk pin busy fin
    add_row(dcbb_pkg::CMD_TICK,          0,     0,     0, 1, 0, 0, 0);
    add_row(dcbb_pkg::CMD_FORCE_ON,      0,     0,     0, 1, 1, 0, 0);
    add_row(dcbb_pkg::CMD_TICK,          0,     0,     0, 1, 1, 0, 0);   // idle tick keeps pin
    add_row(CmdRsvdLo,                 255, 65535, 65535, 1, 1, 0, 0);
    add_row(dcbb_pkg::CMD_PLAY,        255, 65535, 65535, 1, 0, 1, 0);   // all three clamp
    add_row(CmdRsvdHi,                   0,     0,     0, 1, 0, 1, 0);
    add_row(dcbb_pkg::CMD_STOP,          0,     0,     0, 1, 0, 0, 0);
    add_row(dcbb_pkg::CMD_PLAY,         50,     4,     2, 1, 0, 1, 0);
    repeat (8) add_row(dcbb_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    add_row(dcbb_pkg::CMD_PLAY,          0,     2,     1, 1, 0, 1, 0);   // zero duty still runs
    repeat (2) add_row(dcbb_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    add_row(dcbb_pkg::CMD_PLAY,        100,     2,     1, 1, 0, 1, 0);
    repeat (2) add_row(dcbb_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    add_row(dcbb_pkg::CMD_PLAY,         77,     0,     5, 1, 0, 0, 0);
    add_row(dcbb_pkg::CMD_PLAY,         30,    10,     0, 1, 0, 0, 0);
    add_row(dcbb_pkg::CMD_FORCE_OFF,     0,     0,     0, 1, 0, 0, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].chk, dir_rows[i].r);

    while (sent_cnt < NumItems) begin
      if (sent_cnt >= NumItems - CalmItems) idle_en = 1'b0;
      else idle_en = ($urandom_range(0, 3) != 0);
      if (sent_cnt >= HoldAt && sent_cnt < HoldAt + 40 && stall_cnt == 0) hold_req = 1'b1;
      if (!drained && sent_cnt >= DrainAt) begin
        drained = 1'b1;
        cmd_if.valid <= 1'b0;
        while (pin_status_q.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        play_burst();
      end else if (pick == 7) begin
        play_cut($urandom_range(0, 1));
      end else begin
        repeat ($urandom_range(1, 6)) send_rand(rand_cmd());
      end
    end

    cmd_if.valid <= 1'b0;
    while (pin_status_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pin_status_q.size() != 0) note_mismatch("expected results never arrived");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- duty_cycled_beep_burst.f -----
hdl/dcbb_pkg.sv
hdl/dcbb_cmd_if.sv
hdl/dcbb_res_if.sv
hdl/dcbb_core.sv
hdl/duty_cycled_beep_burst.sv
hdl/dcbb_checker.sv
tb/tb_duty_cycled_beep_burst.sv
